>>> hdl/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, character codes and the base64 digit mapping.
// ----------------------------------------------------------------------------
package b64lw_pkg;

	localparam logic [6:0] NL_CHAR  = 7'd10;
	localparam logic [6:0] PAD_CHAR = 7'd61;

	localparam logic [1:0] HAVE_ONE   = 2'd1;
	localparam logic [1:0] HAVE_TWO   = 2'd2;
	localparam logic [1:0] HAVE_THREE = 2'd3;

	typedef struct packed {
		logic [23:0] value;
		logic [1:0]  have;
		logic        last;
	} group_t;

	localparam int GROUP_W = $bits(group_t);

	function automatic logic [6:0] b64_digit(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26)
			r = 7'd65 + {1'b0, v};
		else if (v < 6'd52)
			r = 7'd71 + {1'b0, v};
		else if (v < 6'd62)
			r = {1'b0, v} - 7'd4;
		else if (v == 6'd62)
			r = 7'd43;
		else
			r = 7'd47;
		return r;
	endfunction

endpackage

>>> hdl/base64_encoder_line_wrap.sv
// The byte that completes a group writes it into the queue; its first character then goes into the output register.
// Throughput: one character per cycle while the receiver does not stall, set by the single character output
// register; 4 to 8 characters (with newlines) per 3 bytes.
// A queue of QUEUE_DEPTH groups lets the byte side run ahead of the output.
// Reset (arst_n low) clears grouping, line column, queue and wrap_column to zero.
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Streaming base64 encoder with optional line wrapping at a programmable column.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wrap_we,
	input  logic [7:0] wrap_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] text_char,
	output logic       final_char
);
	import b64lw_pkg::*;

	logic [7:0] wrap_column_q;
	logic       q_full;
	logic       q_push;
	group_t     q_data;
	logic       q_pop;
	logic       head_valid;
	group_t     head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			wrap_column_q <= '0;
		else if (wrap_we)
			wrap_column_q <= wrap_wdata;
	end

	b64lw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	b64lw_queue #(
		.WIDTH (GROUP_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	b64lw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wrap_column (wrap_column_q),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.text_char   (text_char),
		.final_char  (final_char)
	);

endmodule

>>> hdl/b64lw_front.sv
// ----------------------------------------------------------------------------
// b64lw_front
// Gathers message bytes into groups of up to three and pushes each finished
// group, with its byte count and end-of-message flag, to the queue.
// ----------------------------------------------------------------------------
module b64lw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	input  logic                 q_full,
	output logic                 q_push,
	output b64lw_pkg::group_t    q_data
);
	import b64lw_pkg::*;

	logic [15:0] held_bytes_q;
	logic [1:0]  held_count_q;
	logic        take;
	logic        hold;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign hold     = !final_byte && (held_count_q < 2'd2);
	assign q_push   = take && !hold;

	always_comb begin
		q_data.last = final_byte;
		unique case (held_count_q)
			2'd0: begin
				q_data.value = {data_byte, 16'd0};
				q_data.have  = HAVE_ONE;
			end
			2'd1: begin
				q_data.value = {held_bytes_q[15:8], data_byte, 8'd0};
				q_data.have  = HAVE_TWO;
			end
			default: begin
				q_data.value = {held_bytes_q, data_byte};
				q_data.have  = HAVE_THREE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q <= '0;
			held_count_q <= '0;
		end else if (take) begin
			if (hold) begin
				if (held_count_q == 2'd0)
					held_bytes_q <= {data_byte, 8'd0};
				else
					held_bytes_q <= {held_bytes_q[15:8], data_byte};
				held_count_q <= held_count_q + 2'd1;
			end else begin
				held_bytes_q <= '0;
				held_count_q <= '0;
			end
		end
	end

endmodule

>>> hdl/b64lw_queue.sv
// ----------------------------------------------------------------------------
// b64lw_queue
// Small register FIFO between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64lw_queue #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> hdl/b64lw_back.sv
// ----------------------------------------------------------------------------
// b64lw_back
// Turns each queued group into four characters, one per cycle unless the output stalls, inserting
// line-wrap newlines and the trailing newline; drives the output register.
// ----------------------------------------------------------------------------
module b64lw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           wrap_column,
	input  logic                 head_valid,
	input  b64lw_pkg::group_t    head_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [6:0]           text_char,
	output logic                 final_char
);
	import b64lw_pkg::*;

	typedef enum logic [1:0] {PH_CHAR, PH_NL, PH_TAIL} phase_t;

	phase_t     phase_q, phase_d;
	logic [1:0] idx_q, idx_d;
	logic [7:0] col_q, col_d;
	logic       out_valid_q;
	logic [6:0] text_q;
	logic       final_q;

	logic       adv;
	logic       done;
	logic [6:0] ch;
	logic       fin;
	logic       wrap_nz;
	logic [8:0] col_inc;
	logic       hit;
	logic       end_grp;
	logic [6:0] dig;

	assign wrap_nz = (wrap_column != 8'd0);
	assign col_inc = {1'b0, col_q} + 9'd1;
	assign hit     = wrap_nz && (col_inc >= {1'b0, wrap_column});
	assign end_grp = (idx_q == 2'd3);
	assign adv     = head_valid && (!out_valid_q || !out_stall);
	assign pop     = adv && done;

	always_comb begin
		unique case (idx_q)
			2'd0: dig = b64_digit(head_data.value[23:18]);
			2'd1: dig = b64_digit(head_data.value[17:12]);
			2'd2: dig = (head_data.have >= HAVE_TWO) ?
				b64_digit(head_data.value[11:6]) : PAD_CHAR;
			default: dig = (head_data.have == HAVE_THREE) ?
				b64_digit(head_data.value[5:0]) : PAD_CHAR;
		endcase
	end

	always_comb begin
		ch      = dig;
		fin     = 1'b0;
		done    = 1'b0;
		phase_d = PH_CHAR;
		idx_d   = idx_q + 2'd1;
		col_d   = col_q;
		unique case (phase_q)
			PH_CHAR: begin
				idx_d = idx_q;
				if (hit) begin
					phase_d = PH_NL;
					col_d   = '0;
				end else begin
					if (wrap_nz)
						col_d = col_inc[7:0];
					if (end_grp) begin
						if (head_data.last && wrap_nz) begin
							phase_d = PH_TAIL;
						end else begin
							done  = 1'b1;
							fin   = head_data.last;
							idx_d = '0;
							if (head_data.last)
								col_d = '0;
						end
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			PH_NL: begin
				ch = NL_CHAR;
				if (end_grp) begin
					done  = 1'b1;
					fin   = head_data.last;
					idx_d = '0;
				end
			end
			default: begin
				ch    = NL_CHAR;
				fin   = 1'b1;
				done  = 1'b1;
				idx_d = '0;
				col_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CHAR;
			idx_q       <= '0;
			col_q       <= '0;
			out_valid_q <= 1'b0;
			text_q      <= '0;
			final_q     <= 1'b0;
		end else begin
			if (adv) begin
				phase_q     <= phase_d;
				idx_q       <= idx_d;
				col_q       <= col_d;
				out_valid_q <= 1'b1;
				text_q      <= ch;
				final_q     <= fin;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign text_char  = text_q;
	assign final_char = final_q;

endmodule

>>> verif/base64_encoder_line_wrap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap_tb
// Drives byte messages through the encoder under several wrap columns and
// idle patterns, predicts the character stream and checks every transaction.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [6:0] code;
	logic       is_final;
} b64_char_t;

class b64_scoreboard;
	string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	logic [7:0]  wrap_col;
	logic [7:0]  line_col;
	logic [15:0] held;
	logic [1:0]  held_n;
	b64_char_t   expected_chars[$];
	int          mismatches;

	function new();
		wrap_col   = 8'd0;
		line_col   = 8'd0;
		held       = 16'd0;
		held_n     = 2'd0;
		mismatches = 0;
	endfunction

	function void set_wrap(input logic [7:0] v);
		wrap_col = v;
	endfunction

	function int pending();
		return expected_chars.size();
	endfunction

	function logic [6:0] digit(input logic [5:0] v);
		byte c;
		c = alphabet[v];
		return c[6:0];
	endfunction

	function void push_char(input logic [6:0] c);
		expected_chars.push_back('{c, 1'b0});
		if (wrap_col != 8'd0) begin
			if (int'(line_col) + 1 >= int'(wrap_col)) begin
				expected_chars.push_back('{b64lw_pkg::NL_CHAR, 1'b0});
				line_col = 8'd0;
			end else begin
				line_col = line_col + 8'd1;
			end
		end
	endfunction

	// accepted input byte
	function void note_byte(input logic [7:0] b, input logic last);
		logic [23:0] grp;
		int          have;
		if (!last && held_n < 2'd2) begin
			if (held_n == 2'd0)
				held = {b, 8'h00};
			else
				held[7:0] = b;
			held_n = held_n + 2'd1;
			return;
		end
		have = int'(held_n) + 1;
		case (held_n)
			2'd0: grp = {b, 16'h0000};
			2'd1: grp = {held[15:8], b, 8'h00};
			default: grp = {held, b};
		endcase
		push_char(digit(grp[23:18]));
		push_char(digit(grp[17:12]));
		push_char(have >= 2 ? digit(grp[11:6]) : b64lw_pkg::PAD_CHAR);
		push_char(have >= 3 ? digit(grp[5:0]) : b64lw_pkg::PAD_CHAR);
		held_n = 2'd0;
		held   = 16'd0;
		if (last) begin
			if (wrap_col != 8'd0 && line_col != 8'd0)
				expected_chars.push_back('{b64lw_pkg::NL_CHAR, 1'b0});
			line_col = 8'd0;
			expected_chars[$].is_final = 1'b1;
		end
	endfunction

	// accepted output transaction
	function void check_char(input logic [6:0] c, input logic last);
		b64_char_t exp_c;
		if (expected_chars.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected char %0d final %0b", $realtime, c, last);
			return;
		end
		exp_c = expected_chars.pop_front();
		if (c !== exp_c.code || last !== exp_c.is_final) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch char exp %0d got %0d, final exp %0b got %0b",
					$realtime, exp_c.code, c, exp_c.is_final, last);
		end
	endfunction
endclass

module base64_encoder_line_wrap_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic       clk;
	logic       arst_n;
	logic       wrap_we;
	logic [7:0] wrap_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] text_char;
	logic       final_char;

	b64_scoreboard sb = new();

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;
	bit hold_req;
	int msg_left;
	int cycles;

	base64_encoder_line_wrap u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wrap_we    (wrap_we),
		.wrap_wdata (wrap_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.text_char  (text_char),
		.final_char (final_char)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: check, then pick next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_char(text_char, final_char);
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic f);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= d;
		final_byte <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(d, f);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_wrap(input logic [7:0] v);
		wrap_we    <= 1'b1;
		wrap_wdata <= v;
		@(posedge clk);
		wrap_we <= 1'b0;
		sb.set_wrap(v);
	endtask

	// random messages; a phase may end mid-message
	task automatic run_phase(input logic [7:0] wrap, input int n, input bit hold_rx);
		int k;
		drain();
		write_wrap(wrap);
		if (hold_rx)
			hold_req = 1'b1;
		for (k = 0; k < n; k++) begin
			if (msg_left == 0)
				msg_left = ($urandom_range(4) == 0) ? $urandom_range(60, 20)
					: $urandom_range(12, 1);
			msg_left--;
			send_byte(8'($urandom_range(255)), msg_left == 0);
		end
	endtask

	initial begin
		logic [8:0] directed[18];
		int         k;
		directed = '{9'h100, 9'h1ff, 9'h0ff, 9'h100, 9'h000, 9'h000, 9'h100,
			9'h0ff, 9'h0ff, 9'h1ff, 9'h0fb, 9'h0ef, 9'h1be, 9'h04d, 9'h061,
			9'h16e, 9'h055, 9'h1aa};
		clk         = 1'b0;
		arst_n      = 1'b0;
		wrap_we     = 1'b0;
		wrap_wdata  = 8'd0;
		in_valid    = 1'b0;
		data_byte   = 8'd0;
		final_byte  = 1'b0;
		out_stall   = 1'b0;
		tx_idle_pct = 21;
		rx_idle_pct = 45;
		hold_left   = 0;
		hold_req    = 1'b0;
		msg_left    = 0;
		cycles      = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short groups, padding, all-zero and all-one bytes, '+' and '/'
		write_wrap(8'd0);
		for (k = 0; k < 18; k++)
			send_byte(directed[k][7:0], directed[k][8]);
		drain();
		write_wrap(8'd1);
		send_byte(8'ha5, 1'b0);
		send_byte(8'h5a, 1'b1);
		drain();
		write_wrap(8'd255);
		send_byte(8'h3c, 1'b0);
		send_byte(8'hc3, 1'b1);

		run_phase(8'd76, 20, 1'b0);
		run_phase(8'd3, 20, 1'b1);

		tx_idle_pct = 45;
		rx_idle_pct = 21;
		run_phase(8'd0, 20, 1'b0);
		run_phase(8'd255, 20, 1'b0);
		run_phase(8'($urandom_range(10, 1)), 20, 1'b0);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(8'd4, 25, 1'b0);
		run_phase(8'd2, 20, 1'b0);
		run_phase(8'($urandom_range(255, 1)), 20, 1'b0);

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
